/* hw/rtl/ir_pulse_distance_byte_sender_assert.svh */
// Assertion macros used by the IR sender encoder module.
`ifndef IR_PULSE_DISTANCE_BYTE_SENDER_ASSERT_SVH
`define IR_PULSE_DISTANCE_BYTE_SENDER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IPDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IPDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ipds_pkg.sv */
// Types, codes and helpers for the IR pulse-distance byte sender.
package ipds_pkg;

  localparam int DUR_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;

  typedef logic [DUR_W-1:0]     dur_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Input opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // Register indexes
  localparam cfg_idx_t REG_LEADER_MARK  = 3'd0;
  localparam cfg_idx_t REG_LEADER_SPACE = 3'd1;
  localparam cfg_idx_t REG_BIT_MARK     = 3'd2;
  localparam cfg_idx_t REG_ZERO_SPACE   = 3'd3;
  localparam cfg_idx_t REG_ONE_SPACE    = 3'd4;

  // Reset durations
  localparam dur_t RST_LEADER_MARK  = 16'd9000;
  localparam dur_t RST_LEADER_SPACE = 16'd4500;
  localparam dur_t RST_BIT_MARK     = 16'd560;
  localparam dur_t RST_ZERO_SPACE   = 16'd560;
  localparam dur_t RST_ONE_SPACE    = 16'd1600;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_LEAD_MARK  = 5'b00010,
    PH_LEAD_SPACE = 5'b00100,
    PH_BIT_MARK   = 5'b01000,
    PH_BIT_SPACE  = 5'b10000
  } phase_t;

  typedef struct packed {
    dur_t leader_mark;
    dur_t leader_space;
    dur_t bit_mark;
    dur_t zero_space;
    dur_t one_space;
  } timing_t;

  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic send_taken;
    logic frame_done;
  } res_t;

  // A zero duration counts as one tick.
  function automatic dur_t at_least_one(dur_t d);
    return (d == '0) ? dur_t'(1) : d;
  endfunction

endpackage

/* hw/rtl/ipds_in_if.sv */
// Input channel: opcode and byte to send.
interface ipds_in_if;
  import ipds_pkg::*;
  logic  valid;
  logic  ready;
  logic  opcode;
  byte_t send_byte;
  modport source (output valid, output opcode, output send_byte, input ready);
  modport sink   (input valid, input opcode, input send_byte, output ready);
endinterface

/* hw/rtl/ipds_out_if.sv */
// Result channel: carrier level and frame status.
interface ipds_out_if;
  logic valid;
  logic ready;
  logic carrier_on;
  logic busy_res;
  logic send_taken;
  logic frame_done;
  modport source (output valid, output carrier_on, output busy_res,
                  output send_taken, output frame_done, input ready);
  modport sink   (input valid, input carrier_on, input busy_res,
                  input send_taken, input frame_done, output ready);
endinterface

/* hw/rtl/ipds_cfg_if.sv */
// Configuration write channel: register index and data.
interface ipds_cfg_if;
  import ipds_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  dur_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/ipds_cfg_regs.sv */
// Timing registers written through the configuration channel.
module ipds_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  ipds_pkg::cfg_idx_t wr_idx,
  input  ipds_pkg::dur_t     wr_data,
  output ipds_pkg::timing_t  timing
);
  import ipds_pkg::*;

  timing_t timing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.leader_mark  <= RST_LEADER_MARK;
      timing_r.leader_space <= RST_LEADER_SPACE;
      timing_r.bit_mark     <= RST_BIT_MARK;
      timing_r.zero_space   <= RST_ZERO_SPACE;
      timing_r.one_space    <= RST_ONE_SPACE;
    end else if (wr_en) begin
      // Drop writes to indexes beyond the register list
      unique case (wr_idx)
        REG_LEADER_MARK:  timing_r.leader_mark  <= wr_data;
        REG_LEADER_SPACE: timing_r.leader_space <= wr_data;
        REG_BIT_MARK:     timing_r.bit_mark     <= wr_data;
        REG_ZERO_SPACE:   timing_r.zero_space   <= wr_data;
        REG_ONE_SPACE:    timing_r.one_space    <= wr_data;
        default: ;
      endcase
    end
  end

  assign timing = timing_r;

endmodule

/* hw/rtl/ipds_encoder.sv */
// Frame sequencer: phase, tick counter, data shifter and bit counter.
module ipds_encoder #(
  parameter int FRAME_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              opcode,
  input  ipds_pkg::byte_t   send_byte,
  input  ipds_pkg::timing_t timing,
  output ipds_pkg::res_t    res
);
  import ipds_pkg::*;
  `include "ir_pulse_distance_byte_sender_assert.svh"

  localparam int POS_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BITS - 1);

  phase_t           phase_r,      phase_nxt;
  dur_t             ticks_left_r, ticks_left_nxt;
  byte_t            data_shift_r, data_shift_nxt;
  logic [POS_W-1:0] bit_pos_r,    bit_pos_nxt;
  dur_t             ticks_dec;
  logic             taken, done;

  assign ticks_dec = ticks_left_r - dur_t'(1);

  always_comb begin
    phase_nxt      = phase_r;
    ticks_left_nxt = ticks_left_r;
    data_shift_nxt = data_shift_r;
    bit_pos_nxt    = bit_pos_r;
    taken          = 1'b0;
    done           = 1'b0;
    if (step) begin
      if (opcode == OP_SEND) begin
        // A send while busy is ignored
        if (phase_r == PH_IDLE) begin
          data_shift_nxt = send_byte;
          bit_pos_nxt    = '0;
          phase_nxt      = PH_LEAD_MARK;
          ticks_left_nxt = at_least_one(timing.leader_mark);
          taken          = 1'b1;
        end
      end else if (phase_r != PH_IDLE) begin
        ticks_left_nxt = ticks_dec;
        if (ticks_dec == '0) begin
          unique case (phase_r)
            PH_LEAD_MARK: begin
              phase_nxt      = PH_LEAD_SPACE;
              ticks_left_nxt = at_least_one(timing.leader_space);
            end
            PH_LEAD_SPACE: begin
              phase_nxt      = PH_BIT_MARK;
              ticks_left_nxt = at_least_one(timing.bit_mark);
            end
            PH_BIT_MARK: begin
              phase_nxt      = PH_BIT_SPACE;
              ticks_left_nxt = at_least_one(data_shift_r[0] ? timing.one_space
                                                           : timing.zero_space);
            end
            PH_BIT_SPACE: begin
              data_shift_nxt = data_shift_r >> 1;
              if (bit_pos_r == LAST_POS) begin
                bit_pos_nxt    = '0;
                phase_nxt      = PH_IDLE;
                ticks_left_nxt = '0;
                done           = 1'b1;
              end else begin
                bit_pos_nxt = bit_pos_r + POS_W'(1);
                phase_nxt   = PH_BIT_MARK;
                ticks_left_nxt = at_least_one(timing.bit_mark);
              end
            end
            default: begin
              phase_nxt      = PH_IDLE;
              ticks_left_nxt = '0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      ticks_left_r <= '0;
      data_shift_r <= '0;
      bit_pos_r    <= '0;
    end else begin
      phase_r      <= phase_nxt;
      ticks_left_r <= ticks_left_nxt;
      data_shift_r <= data_shift_nxt;
      bit_pos_r    <= bit_pos_nxt;
    end
  end

  assign res.carrier_on = (phase_nxt == PH_LEAD_MARK) || (phase_nxt == PH_BIT_MARK);
  assign res.busy_res   = (phase_nxt != PH_IDLE);
  assign res.send_taken = taken;
  assign res.frame_done = done;

  `IPDS_ASSERT_NOW(a_idle_no_count, phase_r == PH_IDLE, ticks_left_r == '0,
                   "tick counter not clear while idle")
  `IPDS_ASSERT_NOW(a_busy_counting, phase_r != PH_IDLE, ticks_left_r != '0,
                   "tick counter empty during a frame")
  `IPDS_ASSERT_NOW(a_done_from_space, done, step && phase_r == PH_BIT_SPACE
                   && bit_pos_r == LAST_POS, "frame end outside the last bit space")
  `IPDS_ASSERT_NEXT(a_send_starts_leader, taken, phase_r == PH_LEAD_MARK
                    && bit_pos_r == '0, "accepted send did not start the leader")

endmodule

/* hw/rtl/ir_pulse_distance_byte_sender.sv */
// IR pulse-distance byte sender, top level. Every accepted word yields exactly one
// result word; one word is taken per clock cycle whenever the result register is
// empty or being read in the same cycle, so the block sustains one tick per cycle.
// A send word (opcode 1) starts a frame when idle: leader mark, leader space, then
// FRAME_BITS bits LSB first, each a bit mark plus a zero or one space. A tick word
// (opcode 0) advances time by one tick through a 16-bit down-counter. Durations are
// five 16-bit registers (index 0 to 4, reset 9000/4500/560/560/1600); a zero counts
// as one tick. Write them only while no frame is running; the write channel never
// stalls. Results are registered, appearing the cycle after the word is accepted.
module ir_pulse_distance_byte_sender #(
  parameter int FRAME_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  ipds_in_if.sink     in_if,
  ipds_out_if.source  out_if,
  ipds_cfg_if.sink    cfg_if
);
  import ipds_pkg::*;

  timing_t timing;
  res_t    res;
  res_t    res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    step;

  assign cfg_if.ready = 1'b1;

  ipds_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_if.valid),
    .wr_idx  (cfg_if.index),
    .wr_data (cfg_if.data),
    .timing  (timing)
  );

  // Take a word whenever the result register is free or draining this cycle
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign step        = in_if.valid && in_if.ready;

  ipds_encoder #(
    .FRAME_BITS (FRAME_BITS)
  ) u_encoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .opcode    (in_if.opcode),
    .send_byte (in_if.send_byte),
    .timing    (timing),
    .res       (res)
  );

  assign out_valid_nxt = step || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.carrier_on = res_r.carrier_on;
  assign out_if.busy_res   = res_r.busy_res;
  assign out_if.send_taken = res_r.send_taken;
  assign out_if.frame_done = res_r.frame_done;

endmodule
